@@ hw/rtl/dqap_pkg.sv @@
package dqap_pkg;

   localparam int unsigned CharWidth = 8;
   localparam int unsigned AddrWidth = 32;
   localparam int unsigned PartWidth = 9;
   localparam int unsigned DotsWidth = 2;
   localparam int unsigned ProdWidth = 12;

   typedef logic [CharWidth-1:0] char_type;
   typedef logic [AddrWidth-1:0] addr_type;
   typedef logic [PartWidth-1:0] part_type;
   typedef logic [DotsWidth-1:0] dots_type;
   typedef logic [ProdWidth-1:0] prod_type;

   localparam part_type PartMax = part_type'(255);
   localparam part_type PartSat = part_type'(256);
   localparam dots_type DotsMax = dots_type'(3);

   localparam char_type CharEnd  = 8'h00;
   localparam char_type CharDot  = 8'h2E;
   localparam char_type CharZero = 8'h30;
   localparam char_type CharNine = 8'h39;

endpackage

@@ hw/rtl/dqap_req_if.sv @@
interface dqap_req_if import dqap_pkg::*;;
   logic     valid;
   logic     ready;
   char_type char_code;

   modport source (output valid, output char_code, input ready);
   modport sink   (input valid, input char_code, output ready);
endinterface

@@ hw/rtl/dqap_rsp_if.sv @@
interface dqap_rsp_if import dqap_pkg::*;;
   logic     valid;
   logic     ready;
   addr_type address;
   logic     valid_res;

   modport source (output valid, output address, output valid_res, input ready);
   modport sink   (input valid, input address, input valid_res, output ready);
endinterface

@@ hw/rtl/dotted_quad_address_parser.sv @@
// Channel    Direction  Word contents
// req_chan   in         char_code (8 bits, 0 ends the string)
// rsp_chan   out        address (32 bits), valid_res (1 bit)
//
// A character word is registered on acceptance and applied to the parser state in
// the next cycle, so one word is taken every cycle unless a terminator waits. A
// result is written to the result register when its terminator leaves the input
// register, where a terminator waits only while the result register is full and not
// being taken. Reset is synchronous and clears the parser state and both valid flags.
module dotted_quad_address_parser import dqap_pkg::*; (
   input logic           clock,
   input logic           reset,
   dqap_req_if.sink      req_chan,
   dqap_rsp_if.source    rsp_chan
);

   logic     in_valid_ff, in_valid_in;
   char_type char_ff;
   part_type part_ff, part_in;
   dots_type dots_ff, dots_in;
   addr_type addr_ff, addr_in;
   logic     bad_ff, bad_in;
   logic     out_valid_ff, out_valid_in;
   addr_type out_addr_ff, out_addr_in;
   logic     out_ok_ff, out_ok_in;

   logic     is_end, is_digit, is_dot;
   logic     out_free, step;
   logic     part_big, close_bad;
   addr_type closed_addr, shifted_addr;
   prod_type prod;

   assign is_end   = (char_ff == CharEnd);
   assign is_dot   = (char_ff == CharDot);
   assign is_digit = (char_ff >= CharZero) && (char_ff <= CharNine);

   assign out_free = !out_valid_ff || rsp_chan.ready;
   assign step     = in_valid_ff && (!is_end || out_free);

   assign req_chan.ready = !in_valid_ff || step;
   assign in_valid_in    = req_chan.valid || (in_valid_ff && !step);

   assign part_big    = (part_ff > PartMax);
   assign close_bad   = bad_ff || part_big;
   assign closed_addr = {addr_ff[AddrWidth-9:0], part_ff[7:0]};
   assign prod        = {part_ff, 3'b000} + {2'b00, part_ff, 1'b0}
                      + prod_type'(char_ff - CharZero);

   always_comb begin
      case (dots_ff)
         2'd0:    shifted_addr = {closed_addr[7:0], 24'h000000};
         2'd1:    shifted_addr = {closed_addr[15:0], 16'h0000};
         2'd2:    shifted_addr = {closed_addr[23:0], 8'h00};
         default: shifted_addr = closed_addr;
      endcase
   end

   always_comb begin
      part_in      = part_ff;
      dots_in      = dots_ff;
      addr_in      = addr_ff;
      bad_in       = bad_ff;
      out_valid_in = out_valid_ff && !rsp_chan.ready;
      out_addr_in  = out_addr_ff;
      out_ok_in    = out_ok_ff;
      if (step) begin
         if (is_end) begin
            out_valid_in = 1'b1;
            out_ok_in    = !close_bad;
            out_addr_in  = close_bad ? '0 : shifted_addr;
            part_in      = '0;
            dots_in      = '0;
            addr_in      = '0;
            bad_in       = 1'b0;
         end else if (!bad_ff) begin
            if (is_digit) begin
               part_in = (prod > prod_type'(PartSat)) ? PartSat : part_type'(prod);
            end else if (is_dot) begin
               if (dots_ff == DotsMax) begin
                  bad_in = 1'b1;
               end else begin
                  dots_in = dots_ff + dots_type'(1);
                  if (part_big) begin
                     bad_in = 1'b1;
                  end else begin
                     addr_in = closed_addr;
                     part_in = '0;
                  end
               end
            end else begin
               bad_in = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         part_ff      <= '0;
         dots_ff      <= '0;
         addr_ff      <= '0;
         bad_ff       <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         part_ff      <= part_in;
         dots_ff      <= dots_in;
         addr_ff      <= addr_in;
         bad_ff       <= bad_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_chan.valid && req_chan.ready) begin
         char_ff <= req_chan.char_code;
      end
      out_addr_ff <= out_addr_in;
      out_ok_ff   <= out_ok_in;
   end

   assign rsp_chan.valid     = out_valid_ff;
   assign rsp_chan.address   = out_addr_ff;
   assign rsp_chan.valid_res = out_ok_ff;

endmodule
